// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the port checker (mts_checker)
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication into the next cycle, switched off while reset is held
`define MTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mts check failed");

// implication into the next cycle, checked in and out of reset
`define MTS_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mts check failed");

`endif

// ===== rtl/core/mts_pkg.sv =====
// types, character codes and entity tables for the markup tag stripper
// no dependencies
`default_nettype none

package mts_pkg;

    // default depth of the queue between front and back
    localparam int unsigned MTS_QUEUE_DEPTH = 4;

    // character codes
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_DOLL  = 8'h24;
    localparam logic [7:0] CHAR_LBRC  = 8'h7B;
    localparam logic [7:0] CHAR_RBRC  = 8'h7D;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_USCR  = 8'h5F;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_LOW_B = 8'h62;
    localparam logic [7:0] CHAR_LOW_G = 8'h67;
    localparam logic [7:0] CHAR_LOW_L = 8'h6C;
    localparam logic [7:0] CHAR_LOW_N = 8'h6E;
    localparam logic [7:0] CHAR_LOW_P = 8'h70;
    localparam logic [7:0] CHAR_LOW_S = 8'h73;
    localparam logic [7:0] CHAR_LOW_T = 8'h74;
    localparam logic [7:0] CHAR_LOW_U = 8'h75;

    // entity selectors
    localparam logic [1:0] SEL_LT   = 2'd0;
    localparam logic [1:0] SEL_GT   = 2'd1;
    localparam logic [1:0] SEL_NBSP = 2'd2;
    localparam logic [1:0] SEL_BULL = 2'd3;

    // entity match state
    typedef enum logic [2:0] {
        ENT_NONE = 3'd0,
        ENT_AMP  = 3'd1,
        ENT_LT   = 3'd2,
        ENT_GT   = 3'd3,
        ENT_NBSP = 3'd4,
        ENT_BULL = 3'd5
    } ent_kind_t;

    // input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // burst of results caused by one input item:
    // replayed letters, then optional CR LF CR LF, then one optional byte
    typedef struct packed {
        logic [1:0] ent_sel;
        logic [2:0] rep_cnt;
        logic       crlf;
        logic       one_vld;
        logic [7:0] one_byte;
        logic [2:0] total;
    } burst_t;

    // letter idx of an entity name (after the ampersand)
    function automatic logic [7:0] ent_letter(input logic [1:0] sel, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case ({sel, idx})
            {SEL_LT, 3'd0}:   ch = CHAR_LOW_L;
            {SEL_LT, 3'd1}:   ch = CHAR_LOW_T;
            {SEL_LT, 3'd2}:   ch = CHAR_SEMI;
            {SEL_GT, 3'd0}:   ch = CHAR_LOW_G;
            {SEL_GT, 3'd1}:   ch = CHAR_LOW_T;
            {SEL_GT, 3'd2}:   ch = CHAR_SEMI;
            {SEL_NBSP, 3'd0}: ch = CHAR_LOW_N;
            {SEL_NBSP, 3'd1}: ch = CHAR_LOW_B;
            {SEL_NBSP, 3'd2}: ch = CHAR_LOW_S;
            {SEL_NBSP, 3'd3}: ch = CHAR_LOW_P;
            {SEL_NBSP, 3'd4}: ch = CHAR_SEMI;
            {SEL_BULL, 3'd0}: ch = CHAR_LOW_B;
            {SEL_BULL, 3'd1}: ch = CHAR_LOW_U;
            {SEL_BULL, 3'd2}: ch = CHAR_LOW_L;
            {SEL_BULL, 3'd3}: ch = CHAR_LOW_L;
            {SEL_BULL, 3'd4}: ch = CHAR_SEMI;
            default:          ch = 8'h00;
        endcase
        return ch;
    endfunction

    // length of an entity name including the semicolon
    function automatic logic [2:0] ent_len(input logic [1:0] sel);
        logic [2:0] len;
        len = 3'd3;
        unique case (sel)
            SEL_LT, SEL_GT:     len = 3'd3;
            SEL_NBSP, SEL_BULL: len = 3'd5;
            default:            len = 3'd3;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mts_front.sv =====
// front part: accepts input items, tracks tag and entity state, builds one burst per item
// depends on mts_pkg
`default_nettype none

module mts_front
    import mts_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    input  wire logic     q_full,
    output logic          q_push,
    output burst_t        q_data
);

    logic      it_reg, it_next;
    logic      aob_reg, aob_next;
    ent_kind_t kind_reg, kind_next;
    logic [2:0] pos_reg, pos_next;

    logic       fire;
    logic [7:0] b;
    logic       ordinary;
    logic [2:0] kind_off;
    logic [1:0] cur_sel;
    logic [2:0] cur_len;
    logic [2:0] pos_inc;
    logic [2:0] tail_off;
    burst_t     bst;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;

    // decode of the pending entity
    assign kind_off = 3'(kind_reg - ENT_LT);
    assign cur_sel  = kind_off[1:0];
    assign cur_len  = ent_len(cur_sel);
    assign pos_inc  = pos_reg + 3'd1;

    // classify the item and work out the next state
    always_comb begin
        b         = s_data.in_byte;
        ordinary  = 1'b1;
        it_next   = it_reg;
        aob_next  = aob_reg;
        kind_next = kind_reg;
        pos_next  = pos_reg;
        tail_off  = 3'd0;
        bst       = '0;

        // entity matching
        unique case (kind_reg)
            ENT_AMP: begin
                kind_next = ENT_NONE;
                pos_next  = 3'd0;
                priority if (b == ent_letter(SEL_LT, 3'd0)) begin
                    kind_next = ENT_LT;
                    pos_next  = 3'd1;
                    ordinary  = 1'b0;
                end else if (b == ent_letter(SEL_GT, 3'd0)) begin
                    kind_next = ENT_GT;
                    pos_next  = 3'd1;
                    ordinary  = 1'b0;
                end else if (b == ent_letter(SEL_NBSP, 3'd0)) begin
                    kind_next = ENT_NBSP;
                    pos_next  = 3'd1;
                    ordinary  = 1'b0;
                end else if (b == ent_letter(SEL_BULL, 3'd0)) begin
                    kind_next = ENT_BULL;
                    pos_next  = 3'd1;
                    ordinary  = 1'b0;
                end else begin
                    ordinary  = 1'b1;
                end
            end
            ENT_LT, ENT_GT, ENT_NBSP, ENT_BULL: begin
                if (pos_reg < cur_len && b == ent_letter(cur_sel, pos_reg)) begin
                    ordinary = 1'b0;
                    if (pos_inc == cur_len) begin
                        kind_next = ENT_NONE;
                        pos_next  = 3'd0;
                        unique case (cur_sel)
                            SEL_LT:   it_next = 1'b1;
                            SEL_GT:   it_next = 1'b0;
                            SEL_BULL: begin
                                bst.one_vld  = 1'b1;
                                bst.one_byte = CHAR_STAR;
                            end
                            default:  it_next = it_reg;
                        endcase
                    end else begin
                        pos_next = pos_inc;
                    end
                end else begin
                    // broken match: replay the matched letters outside a tag
                    bst.ent_sel = cur_sel;
                    bst.rep_cnt = it_reg ? 3'd0 : pos_reg;
                    kind_next   = ENT_NONE;
                    pos_next    = 3'd0;
                end
            end
            default: begin
                kind_next = ENT_NONE;
                pos_next  = 3'd0;
            end
        endcase

        // ordinary byte handling
        if (ordinary) begin
            if (aob_reg) begin
                aob_next = 1'b0;
                bst.crlf = (b == CHAR_LOW_P);
            end
            unique case (b)
                CHAR_LT: begin
                    it_next  = 1'b1;
                    aob_next = 1'b1;
                end
                CHAR_GT: begin
                    it_next = 1'b0;
                end
                CHAR_AMP: begin
                    kind_next = ENT_AMP;
                    pos_next  = 3'd0;
                end
                CHAR_TAB, CHAR_BSL, CHAR_DOLL, CHAR_LBRC, CHAR_RBRC,
                CHAR_TILDE, CHAR_CARET, CHAR_USCR, CHAR_PCT, CHAR_HASH: begin
                    bst.one_vld = 1'b0;
                end
                CHAR_LF: begin
                    bst.one_vld  = !it_reg;
                    bst.one_byte = CHAR_SPACE;
                end
                default: begin
                    bst.one_vld  = !it_reg;
                    bst.one_byte = b;
                end
            endcase
        end

        // final byte: flush a pending prefix and start fresh
        if (s_data.is_last) begin
            if (kind_next >= ENT_LT && kind_next <= ENT_BULL) begin
                tail_off    = 3'(kind_next - ENT_LT);
                bst.ent_sel = tail_off[1:0];
                bst.rep_cnt = it_next ? 3'd0 : pos_next;
            end
            it_next   = 1'b0;
            aob_next  = 1'b0;
            kind_next = ENT_NONE;
            pos_next  = 3'd0;
        end

        bst.total = bst.rep_cnt + (bst.crlf ? 3'd4 : 3'd0) + {2'b00, bst.one_vld};
    end

    assign q_push = fire && (bst.total != 3'd0);
    assign q_data = bst;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_reg   <= 1'b0;
            aob_reg  <= 1'b0;
            kind_reg <= ENT_NONE;
            pos_reg  <= 3'd0;
        end else if (fire) begin
            it_reg   <= it_next;
            aob_reg  <= aob_next;
            kind_reg <= kind_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mts_queue.sv =====
// short queue of bursts between the front and back parts
// depends on mts_pkg
`default_nettype none

module mts_queue
    import mts_pkg::*;
#(
    parameter int unsigned DEPTH = MTS_QUEUE_DEPTH
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire burst_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        nonempty,
    output burst_t      head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    burst_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mts_back.sv =====
// back part: plays out one burst at a time, one result item per cycle while m_ready is high
// depends on mts_pkg
`default_nettype none

module mts_back
    import mts_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   q_nonempty,
    input  wire burst_t q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  wire logic   m_ready,
    output out_item_t   m_data
);

    burst_t     cur_reg, cur_next;
    logic       vld_reg, vld_next;
    logic [2:0] pos_reg, pos_next;

    logic [2:0] last_pos;
    logic       at_last;
    logic       take;
    logic [2:0] crlf_idx;

    assign last_pos = cur_reg.total - 3'd1;
    assign at_last  = (pos_reg == last_pos);
    assign take     = vld_reg && m_ready;

    // load the next burst when idle or when the current one finishes
    assign q_pop = q_nonempty && (!vld_reg || (take && at_last));

    // byte select within the burst
    assign crlf_idx = pos_reg - cur_reg.rep_cnt;
    always_comb begin
        m_data.run_last = at_last;
        if (pos_reg < cur_reg.rep_cnt) begin
            m_data.out_byte = ent_letter(cur_reg.ent_sel, pos_reg);
        end else if (cur_reg.crlf && crlf_idx < 3'd4) begin
            m_data.out_byte = crlf_idx[0] ? CHAR_LF : CHAR_CR;
        end else begin
            m_data.out_byte = cur_reg.one_byte;
        end
    end
    assign m_valid = vld_reg;

    // sequencer next state
    always_comb begin
        cur_next = cur_reg;
        vld_next = vld_reg;
        pos_next = pos_reg;
        if (q_pop) begin
            cur_next = q_head;
            vld_next = 1'b1;
            pos_next = 3'd0;
        end else if (take) begin
            if (at_last) begin
                vld_next = 1'b0;
                pos_next = 3'd0;
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            pos_reg <= 3'd0;
        end else begin
            vld_reg <= vld_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/markup_tag_stripper.sv =====
// top level of the markup tag stripper: front, burst queue and back
// depends on mts_pkg, mts_front, mts_queue, mts_back
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data  (in_item_t: in_byte, is_last)
//  m_      | out       | m_valid / m_ready  | m_data  (out_item_t: out_byte, run_last)
//
// the front takes one item per cycle while the burst queue has room
// each item gives zero to five result items; the back sends one per cycle
// an item with no results never reaches the queue
// the back's one-byte-per-cycle sequencer sets the sustained rate on long bursts
// reset (aresetn low at a clock edge) clears tag and entity state and empties the queue
// m_ready low stalls the back only; the front runs on until the queue fills
`default_nettype none

module markup_tag_stripper
    import mts_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = MTS_QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic   q_push, q_full, q_pop, q_nonempty;
    burst_t q_wdata, q_head;

    // classify items
    mts_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    // decoupling queue
    mts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    // play out bursts
    mts_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mts_checker.sv =====
// port-level checks for the markup tag stripper, bound to the top level
// depends on mts_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mts_checker
    import mts_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // a stalled result item stays offered
    `MTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // a stalled result item keeps its payload
    `MTS_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_data))

    // a burst runs without gaps until its last item
    `MTS_ASSERT_NEXT(a_burst_gapless, aclk, aresetn,
        m_valid && m_ready && !m_data.run_last, m_valid)

    // reset leaves nothing to send
    `MTS_ASSERT_ALWAYS(a_rst_out_idle, aclk, !aresetn, !m_valid)

    // reset leaves the input side open
    `MTS_ASSERT_ALWAYS(a_rst_in_ready, aclk, !aresetn, s_ready)

endmodule

bind markup_tag_stripper mts_checker u_mts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== bench/markup_tag_stripper_checker.sv =====
// checker for the markup tag stripper: predicts result items and compares them in order
// depends on mts_pkg; watches both channels of the block, drives nothing on them
module markup_tag_stripper_checker
    import mts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_data,
    output int        mismatches,
    output int        pending,
    output int        checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // predicted stripper state
    bit        in_tag;
    bit        after_lt;
    ent_kind_t ent_kind;
    int        ent_pos;

    out_item_t step_out[$];
    out_item_t text_q[$];
    int        errs;
    int        n_checked;

    // entity names as matched after the ampersand
    function automatic string entity_name(input int k);
        case (k)
            0:       return "lt;";
            1:       return "gt;";
            2:       return "nbsp;";
            default: return "bull;";
        endcase
    endfunction

    task automatic emit(input logic [7:0] b);
        step_out.push_back('{out_byte: b, run_last: 1'b0});
    endtask

    task automatic clear_state();
        in_tag   = 1'b0;
        after_lt = 1'b0;
        ent_kind = ENT_NONE;
        ent_pos  = 0;
    endtask

    // matched letters of a broken or flushed entity come out as plain text
    task automatic replay_letters();
        string nm;
        int    i;
        if (ent_kind >= ENT_LT && ent_kind <= ENT_BULL) begin
            nm = entity_name(int'(ent_kind) - int'(ENT_LT));
            for (i = 0; i < ent_pos && i < nm.len(); i++)
                if (!in_tag)
                    emit(nm[i]);
        end
    endtask

    // plain text expected from one input item
    task automatic predict_text(input in_item_t it);
        logic [7:0] b;
        bit         plain;
        int         k;
        int         p;
        string      nm;
        b     = it.in_byte;
        plain = 1'b1;
        step_out.delete();

        // entity matching
        if (ent_kind == ENT_AMP) begin
            ent_kind = ENT_NONE;
            ent_pos  = 0;
            for (k = 0; k < 4; k++) begin
                nm = entity_name(k);
                if (plain && nm[0] == b) begin
                    ent_kind = ent_kind_t'(int'(ENT_LT) + k);
                    ent_pos  = 1;
                    plain    = 1'b0;
                end
            end
        end else if (ent_kind >= ENT_LT && ent_kind <= ENT_BULL) begin
            nm = entity_name(int'(ent_kind) - int'(ENT_LT));
            p  = ent_pos;
            if (p < nm.len() && nm[p] == b) begin
                plain = 1'b0;
                p++;
                if (p == nm.len()) begin
                    if (ent_kind == ENT_LT)
                        in_tag = 1'b1;
                    else if (ent_kind == ENT_GT)
                        in_tag = 1'b0;
                    else if (ent_kind == ENT_BULL)
                        emit(CHAR_STAR);
                    ent_kind = ENT_NONE;
                    ent_pos  = 0;
                end else begin
                    ent_pos = p;
                end
            end else begin
                replay_letters();
                ent_kind = ENT_NONE;
                ent_pos  = 0;
            end
        end else begin
            ent_kind = ENT_NONE;
            ent_pos  = 0;
        end

        // ordinary byte handling
        if (plain) begin
            if (after_lt) begin
                after_lt = 1'b0;
                if (b == CHAR_LOW_P) begin
                    emit(CHAR_CR);
                    emit(CHAR_LF);
                    emit(CHAR_CR);
                    emit(CHAR_LF);
                end
            end
            case (b)
                CHAR_LT: begin
                    in_tag   = 1'b1;
                    after_lt = 1'b1;
                end
                CHAR_GT:  in_tag = 1'b0;
                CHAR_AMP: begin
                    ent_kind = ENT_AMP;
                    ent_pos  = 0;
                end
                CHAR_TAB, CHAR_BSL, CHAR_DOLL, CHAR_LBRC, CHAR_RBRC,
                CHAR_TILDE, CHAR_CARET, CHAR_USCR, CHAR_PCT, CHAR_HASH: ;
                CHAR_LF: if (!in_tag) emit(CHAR_SPACE);
                default: if (!in_tag) emit(b);
            endcase
        end

        // end of text flushes a pending entity and starts afresh
        if (it.is_last) begin
            replay_letters();
            clear_state();
        end

        foreach (step_out[i]) begin
            if (i == step_out.size() - 1)
                step_out[i].run_last = 1'b1;
            text_q.push_back(step_out[i]);
        end
    endtask

    // predict on accepted input items, compare accepted result items
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_state();
            text_q.delete();
        end else begin
            if (s_valid && s_ready)
                predict_text(s_data);
            if (m_valid && m_ready) begin
                n_checked++;
                if (text_q.size() == 0) begin
                    errs++;
                    if (errs <= REPORT_LIMIT)
                        $display("%t: unexpected result item byte %02h last %0b",
                                 $realtime, m_data.out_byte, m_data.run_last);
                end else begin
                    want = text_q.pop_front();
                    if (m_data.out_byte !== want.out_byte ||
                        m_data.run_last !== want.run_last) begin
                        errs++;
                        if (errs <= REPORT_LIMIT)
                            $display("%t: mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                     $realtime, want.out_byte, want.run_last,
                                     m_data.out_byte, m_data.run_last);
                    end
                end
            end
        end
        mismatches <= errs;
        pending    <= text_q.size();
        checked    <= n_checked;
    end

endmodule

// ===== bench/markup_tag_stripper_tb.sv =====
// testbench top for the markup tag stripper: clock, reset, byte stimulus and verdict
// depends on mts_pkg, markup_tag_stripper and markup_tag_stripper_checker
module markup_tag_stripper_tb
    import mts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 280;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int END_CYCLES   = 20;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int mismatches;
    int pending;
    int checked;

    bit    calm       = 1'b0;
    int    hold_asked = 0;
    int    items_sent = 0;
    int    texts_sent = 0;
    int    quiet_cycles = 0;
    string letters  = "abglnpstu ";
    string specials = "\t\\${}~^_%#\n";

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    markup_tag_stripper uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    markup_tag_stripper_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    // watchdog on cycles where no item moves on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int holds_done;
        holds_done = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_asked != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 16);
            @(posedge aclk);
        end
    end

    function automatic string entity_text(input int k);
        case (k)
            0:       return "lt;";
            1:       return "gt;";
            2:       return "nbsp;";
            default: return "bull;";
        endcase
    endfunction

    function automatic logic pick_last();
        return $urandom_range(0, 99) < 3;
    endfunction

    function automatic logic [7:0] pick_letter();
        return letters[$urandom_range(0, letters.len() - 1)];
    endfunction

    // offer one item, with a random gap before it, and wait for acceptance
    task automatic send_item(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 16);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: b, is_last: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (last)
            texts_sent++;
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], last_at_end && i == s.len() - 1);
    endtask

    // stop offering until every predicted result item has come out
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // one random piece of markup: mostly well-formed, some noise and broken entities
    task automatic send_token();
        string nm;
        int    n;
        int    i;
        case ($urandom_range(0, 9))
            0, 1, 2: send_item(pick_letter(), pick_last());
            3: begin
                send_item(CHAR_LT, pick_last());
                send_item($urandom_range(0, 1) ? CHAR_LOW_P : pick_letter(), pick_last());
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    send_item(pick_letter(), pick_last());
                send_item(CHAR_GT, pick_last());
            end
            4: begin
                nm = entity_text($urandom_range(0, 3));
                send_item(CHAR_AMP, pick_last());
                for (i = 0; i < nm.len(); i++)
                    send_item(nm[i], pick_last());
            end
            5: begin
                nm = entity_text($urandom_range(0, 3));
                n  = $urandom_range(0, nm.len() - 1);
                send_item(CHAR_AMP, pick_last());
                for (i = 0; i < n; i++)
                    send_item(nm[i], pick_last());
                send_item(8'($urandom_range(1, 255)), pick_last());
            end
            6: send_item(specials[$urandom_range(0, specials.len() - 1)], pick_last());
            7, 8: send_item(8'($urandom_range(1, 255)), pick_last());
            default: send_item(CHAR_LF, pick_last());
        endcase
    endtask

    initial begin : stimulus
        bit stall_done;
        bit drain_done;
        int target;
        stall_done = 1'b0;
        drain_done = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: byte extremes, paragraph tag, entities, flushes
        send_item(8'h01, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("<p>", 1'b0);
        // bullet while inside a tag opened by an entity
        send_text("&lt;&bull;>", 1'b0);
        // nbsp broken after all four letters: five result items
        send_text("&nbspz", 1'b0);
        send_text("\n#", 1'b0);
        // entity prefix flushed by the final byte
        send_text("&bu", 1'b1);
        // bracket as the final byte
        send_text("<", 1'b1);

        // random markup with one output hold-off, one drain pause and a calm stretch
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if (!stall_done && items_sent >= 100) begin
                stall_done = 1'b1;
                hold_asked <= hold_asked + 1;
                repeat (12) send_item(pick_letter(), 1'b0);
            end else if (!drain_done && items_sent >= 200) begin
                drain_done = 1'b1;
                wait_for_drain();
            end
            calm <= (items_sent >= 130 && items_sent < 180);
            send_token();
        end

        // let the last bursts drain
        wait_for_drain();
        repeat (END_CYCLES) @(posedge aclk);

        $display("sent %0d input items over %0d finished texts, checked %0d result items",
                 items_sent, texts_sent, checked);
        $display("covered tags, all four entities whole and broken, flushes and output stalls");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== markup_tag_stripper.f =====
+incdir+rtl/core
rtl/core/mts_pkg.sv
rtl/core/mts_front.sv
rtl/core/mts_queue.sv
rtl/core/mts_back.sv
rtl/core/markup_tag_stripper.sv
rtl/core/mts_checker.sv
bench/markup_tag_stripper_checker.sv
bench/markup_tag_stripper_tb.sv
